// ----- sv/pls_pkg.sv -----
// Package for the ply load superposition block: sizes, opcodes, command
// and state types shared by the front end, command queue and back end.
// No dependencies.
package pls_pkg;

    // Stack-up and table geometry
    localparam int MAX_PLIES = 64;
    localparam int UNIT_LOADS = 6;
    localparam int NUM_COMPS = 6;
    localparam int TABLE_ROWS = MAX_PLIES * UNIT_LOADS;
    localparam int ROW_W = $clog2(TABLE_ROWS);
    localparam int PLY_W = 6;
    localparam int LOAD_IDX_W = 3;
    localparam int CFG_W = 7;
    localparam int VAL_W = 32;
    localparam int PROD_W = 2 * VAL_W;
    localparam int RES_W = 64;
    localparam int ACC_W = PROD_W + 3;

    // Plies processed per load case never exceed this bound
    localparam int PLY_LIMIT_INT = (MAX_PLIES < 64) ? MAX_PLIES : 64;
    localparam logic [CFG_W-1:0] PLY_LIMIT = CFG_W'(PLY_LIMIT_INT);
    localparam logic [CFG_W-1:0] PLY_COUNT_RESET = CFG_W'(1);

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW = $clog2(OUT_DEPTH);
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

    // Input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Last unit load index within a ply
    localparam logic [LOAD_IDX_W-1:0] LOAD_LAST = LOAD_IDX_W'(UNIT_LOADS - 1);
    localparam logic [LOAD_IDX_W-1:0] LOAD_FIRST = LOAD_IDX_W'(0);

    typedef logic [NUM_COMPS-1:0][VAL_W-1:0] row_t;
    typedef logic [NUM_COMPS-1:0][RES_W-1:0] res_row_t;

    typedef enum logic {
        CMD_WRITE,
        CMD_LOAD
    } cmd_kind_t;

    // One classified command between front and back
    typedef struct packed {
        cmd_kind_t        kind;
        logic [ROW_W-1:0] row;
        logic [PLY_W-1:0] last_ply;
        row_t             value;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // Saturate an exact sum to a signed 64-bit result
    function automatic logic [RES_W-1:0] sat64(input logic signed [ACC_W-1:0] a);
        logic [RES_W-1:0] r;
        if (a[ACC_W-1:RES_W-1] == {(ACC_W-RES_W+1){1'b0}} ||
            a[ACC_W-1:RES_W-1] == {(ACC_W-RES_W+1){1'b1}}) begin
            r = a[RES_W-1:0];
        end else if (a[ACC_W-1]) begin
            r = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(RES_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- sv/pls_front.sv -----
// Front end of the ply load superposition block: holds the ply count
// register, accepts input items and classifies them into commands.
// Depends on pls_pkg.
module pls_front
    import pls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  push,
    input  logic                  opcode,
    input  logic [PLY_W-1:0]      ply_index,
    input  logic [LOAD_IDX_W-1:0] unit_load_index,
    input  row_t                  value,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [CFG_W-1:0] ply_count_reg;
    logic [CFG_W-1:0] ply_eff;
    logic             accept;
    logic             row_ok;

    // Hold the ply count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ply_count_reg <= PLY_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            ply_count_reg <= cfg_data;
        end
    end

    // Clamp the ply count into the supported range
    always_comb
    begin
        if (ply_count_reg == '0)
        begin
            ply_eff = CFG_W'(1);
        end
        else if (ply_count_reg > PLY_LIMIT)
        begin
            ply_eff = PLY_LIMIT;
        end
        else
        begin
            ply_eff = ply_count_reg;
        end
    end

    // Classify: drop writes outside the table, forward the rest
    assign accept = push && !q_full;
    assign row_ok = (unit_load_index < LOAD_IDX_W'(UNIT_LOADS)) &&
                    (32'(ply_index) < 32'(MAX_PLIES));

    always_comb
    begin
        q_cmd.kind     = (opcode == OP_LOAD) ? CMD_LOAD : CMD_WRITE;
        q_cmd.row      = ROW_W'(ROW_W'(ply_index) * ROW_W'(UNIT_LOADS)) +
                         ROW_W'(unit_load_index);
        q_cmd.last_ply = PLY_W'(ply_eff - CFG_W'(1));
        q_cmd.value    = value;
        q_push         = accept && ((opcode == OP_LOAD) || row_ok);
    end

endmodule

// ----- sv/pls_cmd_queue.sv -----
// Short command queue between front and back end of the ply load
// superposition block. Depends on pls_pkg.
module pls_cmd_queue
    import pls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_PW-1:0] wr_ptr_reg;
    logic [CMD_PW-1:0] rd_ptr_reg;
    logic [CMD_CW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CMD_CW'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == CMD_DEPTH - 1) ? '0 :
                              CMD_PW'(wr_ptr_reg + CMD_PW'(1));
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == CMD_DEPTH - 1) ? '0 :
                              CMD_PW'(rd_ptr_reg + CMD_PW'(1));
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CMD_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CMD_CW'(1);
            end
        end
    end

endmodule

// ----- sv/pls_back.sv -----
// Back end of the ply load superposition block: unit table memory, six
// multiply-accumulate lanes, ply sequencer and result queue.
// Depends on pls_pkg.
module pls_back
    import pls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic [PLY_W-1:0] out_ply,
    output res_row_t         out_res,
    output logic             last_ply
);

    // Unit table: one row holds six components of one ply and unit load
    row_t mem [TABLE_ROWS];

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             mem_we;
    logic             load_take;
    logic             issue;
    logic             credit_ok;

    // Issue stage
    logic [PLY_W-1:0]      ply_reg;
    logic [PLY_W-1:0]      last_reg;
    logic [LOAD_IDX_W-1:0] k_reg;
    logic [ROW_W-1:0]      row_reg;
    row_t                  load_reg;

    // Read stage
    logic                  s1_valid_reg;
    logic [LOAD_IDX_W-1:0] s1_k_reg;
    logic [PLY_W-1:0]      s1_ply_reg;
    logic                  s1_last_reg;
    logic [VAL_W-1:0]      s1_load_reg;
    row_t                  rd_data_reg;

    // Multiply stage
    logic                         s2_valid_reg;
    logic [LOAD_IDX_W-1:0]        s2_k_reg;
    logic [PLY_W-1:0]             s2_ply_reg;
    logic                         s2_last_reg;
    logic signed [PROD_W-1:0]     prod_reg [NUM_COMPS];

    // Accumulate stage
    logic                         s3_done_reg;
    logic [PLY_W-1:0]             s3_ply_reg;
    logic                         s3_last_reg;
    logic signed [ACC_W-1:0]      acc_reg [NUM_COMPS];

    // Result queue
    logic [PLY_W-1:0]  oq_ply_reg  [OUT_DEPTH];
    logic              oq_last_reg [OUT_DEPTH];
    res_row_t          oq_res_reg  [OUT_DEPTH];
    logic [OUT_PW-1:0] oq_wr_reg;
    logic [OUT_PW-1:0] oq_rd_reg;
    logic [OUT_CW-1:0] oq_count_reg;
    logic [OUT_CW-1:0] inflight_reg;
    logic              oq_pop;
    res_row_t          sat_row;

    // Reserve result queue space before a ply starts
    assign credit_ok = (32'(oq_count_reg) + 32'(inflight_reg)) < OUT_DEPTH;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_LOAD)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (issue && k_reg == LOAD_LAST && ply_reg == last_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop   = 1'b0;
        mem_we    = 1'b0;
        load_take = 1'b0;
        issue     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop   = cmd_valid;
                mem_we    = cmd_valid && cmd.kind == CMD_WRITE;
                load_take = cmd_valid && cmd.kind == CMD_LOAD;
            end
            BK_RUN:
            begin
                issue = (k_reg != LOAD_FIRST) || credit_ok;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write table rows and read one row per issue
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.row] <= cmd.value;
        end
        if (issue)
        begin
            rd_data_reg <= mem[row_reg];
        end
    end

    // Sequence plies and unit loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ply_reg <= '0;
            k_reg   <= '0;
            row_reg <= '0;
        end
        else if (load_take)
        begin
            ply_reg <= '0;
            k_reg   <= '0;
            row_reg <= '0;
        end
        else if (issue)
        begin
            row_reg <= ROW_W'(row_reg + ROW_W'(1));
            if (k_reg == LOAD_LAST)
            begin
                k_reg   <= '0;
                ply_reg <= PLY_W'(ply_reg + PLY_W'(1));
            end
            else
            begin
                k_reg <= LOAD_IDX_W'(k_reg + LOAD_IDX_W'(1));
            end
        end
    end

    // Hold load case payload
    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            load_reg <= cmd.value;
            last_reg <= cmd.last_ply;
        end
        if (issue)
        begin
            s1_load_reg <= load_reg[k_reg];
            s1_k_reg    <= k_reg;
            s1_ply_reg  <= ply_reg;
            s1_last_reg <= (ply_reg == last_reg);
        end
        if (s1_valid_reg)
        begin
            s2_k_reg    <= s1_k_reg;
            s2_ply_reg  <= s1_ply_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg && s2_k_reg == LOAD_LAST)
        begin
            s3_ply_reg  <= s2_ply_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Multiply and accumulate in six lanes
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMPS; c++)
        begin
            if (s1_valid_reg)
            begin
                prod_reg[c] <= PROD_W'($signed(s1_load_reg)) *
                               PROD_W'($signed(rd_data_reg[c]));
            end
            if (s2_valid_reg)
            begin
                if (s2_k_reg == LOAD_FIRST)
                begin
                    acc_reg[c] <= ACC_W'(prod_reg[c]);
                end
                else
                begin
                    acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
                end
            end
        end
    end

    // Advance stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_done_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_done_reg  <= s2_valid_reg && s2_k_reg == LOAD_LAST;
        end
    end

    // Saturate finished sums
    always_comb
    begin
        for (int c = 0; c < NUM_COMPS; c++)
        begin
            sat_row[c] = sat64(acc_reg[c]);
        end
    end

    // Store results
    always_ff @(posedge clk)
    begin
        if (s3_done_reg)
        begin
            oq_ply_reg[oq_wr_reg]  <= s3_ply_reg;
            oq_last_reg[oq_wr_reg] <= s3_last_reg;
            oq_res_reg[oq_wr_reg]  <= sat_row;
        end
    end

    assign empty    = (oq_count_reg == '0);
    assign oq_pop   = pop && !empty;
    assign out_ply  = oq_ply_reg[oq_rd_reg];
    assign out_res  = oq_res_reg[oq_rd_reg];
    assign last_ply = oq_last_reg[oq_rd_reg];

    // Track result queue fill and plies in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (s3_done_reg)
            begin
                oq_wr_reg <= OUT_PW'(oq_wr_reg + OUT_PW'(1));
            end
            if (oq_pop)
            begin
                oq_rd_reg <= OUT_PW'(oq_rd_reg + OUT_PW'(1));
            end
            if (s3_done_reg && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + OUT_CW'(1);
            end
            else if (oq_pop && !s3_done_reg)
            begin
                oq_count_reg <= oq_count_reg - OUT_CW'(1);
            end
            if ((issue && k_reg == LOAD_FIRST) && !s3_done_reg)
            begin
                inflight_reg <= inflight_reg + OUT_CW'(1);
            end
            else if (s3_done_reg && !(issue && k_reg == LOAD_FIRST))
            begin
                inflight_reg <= inflight_reg - OUT_CW'(1);
            end
        end
    end

    // Reserved space never exceeds the result queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(oq_count_reg) + 32'(inflight_reg)) <= OUT_DEPTH)
        else $error("result queue overcommitted");

    // A finished ply always finds room in the result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_done_reg |-> (32'(oq_count_reg) < OUT_DEPTH))
        else $error("result written into full queue");

    // Commands are taken only between load cases
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == BK_IDLE && !issue))
        else $error("command taken during a load case");

    // A ply starts only with a reserved result slot
    a_ply_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && k_reg == LOAD_FIRST) |-> credit_ok)
        else $error("ply started without result space");

endmodule

// ----- sv/ply_load_superposition.sv -----
// Ply load superposition block, top level: joins front end, command queue
// and back end. Depends on pls_pkg, pls_front, pls_cmd_queue and pls_back.
//
// Input side is a queue: an item transfers at an edge with push high and
// full low. Opcode 0 writes one unit table row (six Q8.24 entries for one
// ply and unit load); opcode 1 applies a load case (six Q24.8 loads).
// Result side is a queue: while empty is low the oldest result is on the
// result ports; it transfers at an edge with pop high. A load case yields
// one result per ply, ply 0 first, last_ply set on the final one. Write
// the ply count through cfg_we/cfg_data only while the block is idle.
// A load case holds the back end while it is taken and then while its
// table rows are read, one 192-bit row per cycle unless a ply waits for
// result queue space. A table write is taken while the back end is idle.
// The two-entry command queue lets the input side accept up to two more
// items while a load case runs. If the receiver stalls, the four-entry
// result queue fills and the back end waits before the next ply.
// Reset empties both queues and sets the ply count to one; the unit table
// holds no defined contents until written.
module ply_load_superposition
    import pls_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [PLY_W-1:0]            ply_index,
    input  logic [LOAD_IDX_W-1:0]       unit_load_index,
    input  logic signed [VAL_W-1:0]     value_0,
    input  logic signed [VAL_W-1:0]     value_1,
    input  logic signed [VAL_W-1:0]     value_2,
    input  logic signed [VAL_W-1:0]     value_3,
    input  logic signed [VAL_W-1:0]     value_4,
    input  logic signed [VAL_W-1:0]     value_5,
    output logic                        empty,
    input  logic                        pop,
    output logic [PLY_W-1:0]            out_ply,
    output logic signed [RES_W-1:0]     stress_1,
    output logic signed [RES_W-1:0]     stress_2,
    output logic signed [RES_W-1:0]     stress_12,
    output logic signed [RES_W-1:0]     strain_1,
    output logic signed [RES_W-1:0]     strain_2,
    output logic signed [RES_W-1:0]     strain_12,
    output logic                        last_ply
);

    row_t     in_row;
    cmd_t     front_cmd;
    logic     front_push;
    cmd_t     back_cmd;
    logic     q_empty;
    logic     back_pop;
    res_row_t res;

    // Gather payload fields into one row
    assign in_row = {value_5, value_4, value_3, value_2, value_1, value_0};

    pls_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .push            (push),
        .opcode          (opcode),
        .ply_index       (ply_index),
        .unit_load_index (unit_load_index),
        .value           (in_row),
        .q_full          (full),
        .q_push          (front_push),
        .q_cmd           (front_cmd)
    );

    pls_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (full),
        .pop      (back_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    pls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (back_pop),
        .empty     (empty),
        .pop       (pop),
        .out_ply   (out_ply),
        .out_res   (res),
        .last_ply  (last_ply)
    );

    // Split the result row onto its ports
    assign stress_1  = res[0];
    assign stress_2  = res[1];
    assign stress_12 = res[2];
    assign strain_1  = res[3];
    assign strain_2  = res[4];
    assign strain_12 = res[5];

endmodule
